// ===== hw/rtl/qrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrq_pkg
// Types, codes and helpers for the ready-queue unit.
// ----------------------------------------------------------------------------
package qrq_pkg;

  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_ARRIVE  = 2'd0,
    OP_REQUEUE = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SRT  = 2'd1,
    MODE_RR   = 2'd2,
    MODE_PRIO = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  task_id;
    logic [15:0] remaining_time;
    logic [7:0]  task_priority;
    logic [2:0]  core_index;
  } in_word_t;

  typedef struct packed {
    logic               dispatched_valid;
    logic [5:0]         dispatched_id;
    logic               queue_empty;
    logic               insert_dropped;
    logic               preempt_valid;
    logic [2:0]         preempt_core;
    logic [COUNT_W-1:0] queue_count;
  } out_word_t;

  typedef struct packed {
    logic [5:0]  id;
    logic [15:0] rtime;
    logic [7:0]  prio;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_RD,
    ST_SC_CK,
    ST_SH_RD,
    ST_SH_WR,
    ST_WRITE,
    ST_PRE_RD,
    ST_PRE_CK,
    ST_PRE_END,
    ST_HD_RD,
    ST_HD_CK,
    ST_DONE
  } state_t;

  function automatic logic [15:0] key_of(input slot_t s, input logic [1:0] mode);
    return (mode == MODE_SRT) ? s.rtime : {8'd0, s.prio};
  endfunction

endpackage

// ===== hw/rtl/qrq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module qrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/multi_policy_ready_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_ready_queue_unit
// Ready queue for a task scheduler: FCFS/RR append, sorted insert by remaining
// time or priority, dispatch to a core, core release, preemption report.
// Steps: release, empty dispatch or dropped insert go straight to the result;
// dispatch reads the head entry; append writes at the tail; sorted insert does
// a forward key scan, then a one-entry-per-cycle shift in the slot RAM, then
// the write; a priority arrival then scans the cores for a preemption.
// One word in flight: a new word is taken only once the last has passed its
// result to out, and the next word is taken while a result waits at out.
// Reset: queue empty, all cores idle, policy first-come; RAM is not cleared.
// ----------------------------------------------------------------------------
module multi_policy_ready_queue_unit
  import qrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int CORE_COUNT  = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

  state_t            state, state_next;
  logic [1:0]        mode;
  in_word_t          item, item_next;
  logic [LW-1:0]     len, len_next;
  logic [IW-1:0]     head, head_next;
  logic [LW-1:0]     idx, idx_next;
  logic [LW-1:0]     pos, pos_next;
  logic [CW-1:0]     cidx, cidx_next;
  logic              found, found_next;
  logic [7:0]        best, best_next;
  out_word_t         res, res_next;
  logic [CORE_COUNT-1:0] core_busy, core_busy_next;

  logic              q_we;
  logic [IW-1:0]     q_waddr, q_raddr;
  slot_t             q_wdata, q_rdata;
  logic              c_we;
  logic [CW-1:0]     c_waddr, c_raddr;
  logic [7:0]        c_wdata, c_rdata;

  slot_t             new_slot;
  logic              core_ok;
  logic [CW+2:0]     core_ext;
  logic [CW-1:0]     core_addr;

  function automatic logic [IW-1:0] phys(input logic [LW-1:0] i);
    logic [LW:0] s;
    s = (LW+1)'(head) + (LW+1)'(i);
    if (s >= (LW+1)'(QUEUE_DEPTH)) begin
      s = s - (LW+1)'(QUEUE_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  qrq_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  qrq_ram #(.WIDTH(8), .DEPTH(CORE_COUNT)) u_core_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign new_slot  = '{id: item.task_id, rtime: item.remaining_time,
                       prio: item.task_priority};
  assign core_ok   = (32'(item.core_index) < 32'(CORE_COUNT));
  assign core_ext  = (CW+3)'(item.core_index);
  assign core_addr = core_ext[CW-1:0];

  always_comb begin
    state_next     = state;
    item_next      = item;
    len_next       = len;
    head_next      = head;
    idx_next       = idx;
    pos_next       = pos;
    cidx_next      = cidx;
    found_next     = found;
    best_next      = best;
    res_next       = res;
    core_busy_next = core_busy;
    q_we           = 1'b0;
    q_waddr        = phys(pos);
    q_wdata        = new_slot;
    q_raddr        = phys(idx);
    c_we           = 1'b0;
    c_waddr        = core_addr;
    c_wdata        = q_rdata.prio;
    c_raddr        = cidx;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          item_next = in_data;
          res_next  = '0;
          idx_next  = '0;
          unique case (in_data.opcode)
            OP_ARRIVE, OP_REQUEUE: begin
              if (len == LW'(QUEUE_DEPTH)) begin
                res_next.insert_dropped = 1'b1;
                state_next = ST_DONE;
              end else if ((mode == MODE_SRT || mode == MODE_PRIO) && len != '0) begin
                state_next = ST_SC_RD;
              end else begin
                pos_next   = len;
                state_next = ST_WRITE;
              end
            end
            OP_DISPATCH: begin
              if (len == '0) begin
                res_next.queue_empty = 1'b1;
                state_next = ST_DONE;
              end else begin
                state_next = ST_HD_RD;
              end
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_SC_RD: begin
        state_next = ST_SC_CK;
      end

      ST_SC_CK: begin
        if (key_of(q_rdata, mode) > key_of(new_slot, mode)) begin
          pos_next   = idx;
          idx_next   = len - LW'(1);
          state_next = ST_SH_RD;
        end else if (idx == len - LW'(1)) begin
          pos_next   = len;
          state_next = ST_WRITE;
        end else begin
          idx_next = idx + LW'(1);
          q_raddr  = phys(idx + LW'(1));
        end
      end

      ST_SH_RD: begin
        state_next = ST_SH_WR;
      end

      ST_SH_WR: begin
        q_we    = 1'b1;
        q_waddr = phys(idx + LW'(1));
        q_wdata = q_rdata;
        if (idx == pos) begin
          state_next = ST_WRITE;
        end else begin
          idx_next = idx - LW'(1);
          q_raddr  = phys(idx - LW'(1));
        end
      end

      ST_WRITE: begin
        q_we     = 1'b1;
        len_next = len + LW'(1);
        if (item.opcode == OP_ARRIVE && mode == MODE_PRIO) begin
          cidx_next  = '0;
          found_next = 1'b0;
          best_next  = '0;
          state_next = ST_PRE_RD;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_PRE_RD: begin
        state_next = ST_PRE_CK;
      end

      ST_PRE_CK: begin
        if (core_busy[cidx] && (!found || c_rdata > best)) begin
          found_next = 1'b1;
          best_next  = c_rdata;
          res_next.preempt_core = 3'(cidx);
        end
        if (cidx == CW'(CORE_COUNT - 1)) begin
          state_next = ST_PRE_END;
        end else begin
          cidx_next = cidx + CW'(1);
          c_raddr   = cidx + CW'(1);
        end
      end

      ST_PRE_END: begin
        if (found && best > item.task_priority) begin
          res_next.preempt_valid = 1'b1;
        end else begin
          res_next.preempt_core = '0;
        end
        state_next = ST_DONE;
      end

      ST_HD_RD: begin
        state_next = ST_HD_CK;
      end

      ST_HD_CK: begin
        res_next.dispatched_valid = 1'b1;
        res_next.dispatched_id    = q_rdata.id;
        head_next = phys(LW'(1));
        len_next  = len - LW'(1);
        if (core_ok) begin
          c_we = 1'b1;
          core_busy_next[core_addr] = 1'b1;
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (item.opcode == OP_RELEASE && core_ok) begin
          core_busy_next[core_addr] = 1'b0;
        end
        res_next.queue_count = COUNT_W'(len);
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end else begin
          core_busy_next = core_busy;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FCFS;
      len       <= '0;
      head      <= '0;
      core_busy <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      head      <= head_next;
      core_busy <= core_busy_next;
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item  <= item_next;
    idx   <= idx_next;
    pos   <= pos_next;
    cidx  <= cidx_next;
    found <= found_next;
    best  <= best_next;
    res   <= res_next;
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data <= res_next;
    end
  end

endmodule
